// File: rtl/box_blur_3x3_rgb_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 RGB box blur
// Shared property wrappers, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_RGB_DEFINES_SVH
`define BOX_BLUR_3X3_RGB_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define BB3_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("bb3 same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define BB3_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("bb3 next-cycle check failed");

`endif

// File: rtl/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// Constants, types and the divisor table of the 3x3 RGB box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

	// Line store depth and derived widths
	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int WEFF_W    = $clog2(MAX_WIDTH + 1);
	localparam int PEND_W    = $clog2(MAX_WIDTH + 2);
	localparam int ROW_W     = 16;

	// Pixel format
	localparam int CH_W  = 8;
	localparam int NCH   = 3;
	localparam int PIX_W = CH_W * NCH;

	// Configuration port
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 1;
	localparam int WIDTH_REG_W = 11;
	localparam int RST_WIDTH   = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
	localparam int RST_HEIGHT  = 480;

	// Arithmetic widths: sum of nine channels, then 2*sum + count
	localparam int SUM_W = $clog2(9 * 255 + 1);
	localparam int X_W   = SUM_W + 1;
	localparam int CNT_W = 4;

	// Reciprocals for divide by 3 and 9, exact for dividends below 2**15
	localparam int RECIP_SHIFT = 16;
	localparam int RECIP_3     = (2 ** RECIP_SHIFT + 2) / 3;
	localparam int RECIP_9     = (2 ** RECIP_SHIFT + 8) / 9;
	localparam int RECIP_W     = $clog2(RECIP_3 + 1);

	typedef logic [NCH-1:0][CH_W-1:0] rgb_t;

	typedef enum logic [0:0] {
		CMD_PIXEL = 1'b0,
		CMD_DRAIN = 1'b1
	} cmd_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_idx_e;

	typedef enum logic [1:0] {
		DIV_1,
		DIV_3,
		DIV_9
	} div_kind_e;

	// Which window borders fall outside the frame
	typedef struct packed {
		logic top;
		logic bot;
		logic left;
		logic right;
	} bnd_t;

	// 2*count = 2**shift * (1, 3 or 9)
	typedef struct packed {
		logic [1:0]       shift;
		div_kind_e        kind;
		logic [CNT_W-1:0] count;
	} div_plan_t;

	function automatic div_plan_t div_plan(input logic [1:0] rows_n, input logic [1:0] cols_n);
		div_plan_t p;
		p.shift = 2'd1;
		p.kind  = DIV_1;
		p.count = 4'd1;
		case ({rows_n, cols_n})
			4'b0101: begin
				p.shift = 2'd1; p.kind = DIV_1; p.count = 4'd1;
			end
			4'b0110, 4'b1001: begin
				p.shift = 2'd2; p.kind = DIV_1; p.count = 4'd2;
			end
			4'b0111, 4'b1101: begin
				p.shift = 2'd1; p.kind = DIV_3; p.count = 4'd3;
			end
			4'b1010: begin
				p.shift = 2'd3; p.kind = DIV_1; p.count = 4'd4;
			end
			4'b1011, 4'b1110: begin
				p.shift = 2'd2; p.kind = DIV_3; p.count = 4'd6;
			end
			4'b1111: begin
				p.shift = 2'd1; p.kind = DIV_9; p.count = 4'd9;
			end
			default: begin
				p.shift = 2'd1; p.kind = DIV_1; p.count = 4'd1;
			end
		endcase
		return p;
	endfunction

endpackage

// File: rtl/bb3_ram.sv
// ----------------------------------------------------------------------------
// bb3_ram
// Simple dual-port RAM, one write and one registered read port, read-old.
// ----------------------------------------------------------------------------
module bb3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/box_blur_3x3_rgb.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// Streaming 3x3 box blur of RGB frames with one shared line store.
// ----------------------------------------------------------------------------
// Channel   Handshake                    Payload
// pixels    s_axis_tvalid/s_axis_tready  tdata: red, green, blue; tuser: cmd
// results   m_axis_tvalid/m_axis_tready  tdata: red, green, blue; tlast: last pixel
// config    cfg_wr_en                    cfg_index, cfg_data
//
// One item per clock while tready is high; the line store takes one read and
// one write per cycle. An emitted result passes the stage 1, 2 and 3 registers
// and the output register to m_axis. A one-row frame ends with a tready-low step.
// A stalled result stalls the whole pipe and drops s_axis_tready.
// Reset clears control state only; the line store holds no reset value.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [bb3_pkg::PIX_W-1:0]     s_axis_tdata,  // in_red, in_green, in_blue
	input  logic [0:0]                    s_axis_tuser,  // cmd
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [bb3_pkg::PIX_W-1:0]     m_axis_tdata,  // out_red, out_green, out_blue
	output logic                          m_axis_tlast,
	input  logic                          cfg_wr_en,
	input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bb3_pkg::CFG_W-1:0]     cfg_data
);

	localparam int COL_W  = bb3_pkg::COL_W;
	localparam int ROW_W  = bb3_pkg::ROW_W;
	localparam int PEND_W = bb3_pkg::PEND_W;
	localparam int WEFF_W = bb3_pkg::WEFF_W;
	localparam int PIX_W  = bb3_pkg::PIX_W;
	localparam int NCH    = bb3_pkg::NCH;
	localparam int CH_W   = bb3_pkg::CH_W;
	localparam int SUM_W  = bb3_pkg::SUM_W;
	localparam int X_W    = bb3_pkg::X_W;
	localparam int PROD_W = bb3_pkg::X_W + bb3_pkg::RECIP_W;

	// Frame geometry
	logic [COL_W-1:0]  wlast_q;
	logic [ROW_W-1:0]  hlast_q;
	logic [PEND_W-1:0] pend_max_q;

	// Positions and progress
	logic [COL_W-1:0]  in_col_q;
	logic [ROW_W-1:0]  in_row_q;
	logic [COL_W-1:0]  out_col_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [PEND_W-1:0] pend_q;
	logic              done_q;
	logic              prime_q;

	// Config decode
	logic [bb3_pkg::WIDTH_REG_W-1:0] raw_w;
	logic [WEFF_W-1:0]               w_eff;
	logic [ROW_W-1:0]                raw_h;

	// Stage 0
	logic              advance;
	logic              acc;
	logic              is_pix;
	logic              restart;
	logic              drain_ok;
	logic              s0_go;
	logic              s0_emit;
	logic              s0_we;
	logic [COL_W-1:0]  col_cur;
	logic [ROW_W-1:0]  row_cur;
	logic [PEND_W-1:0] pend_cur;
	logic [COL_W-1:0]  ocol_cur;
	logic [ROW_W-1:0]  orow_cur;
	logic              col_wrap;
	logic [COL_W-1:0]  col_nxt;
	logic [ROW_W-1:0]  row_nxt;
	logic              frame_end;
	logic [PEND_W-1:0] pend_nxt;
	logic [COL_W-1:0]  ocol_nxt;
	logic [ROW_W-1:0]  orow_nxt;
	bb3_pkg::bnd_t     bnd_s0;

	// Stage 1
	logic              vld_s1;
	logic              emit_s1;
	logic              we_s1;
	logic [COL_W-1:0]  addr_s1;
	bb3_pkg::rgb_t     pix_s1;
	bb3_pkg::bnd_t     bnd_s1;
	logic [2*PIX_W-1:0] rd_data;
	logic               fwd_hit;
	bb3_pkg::rgb_t      col_up;
	bb3_pkg::rgb_t      col_mid;
	logic               mem_we;
	logic               fwd_vld_q;
	logic [COL_W-1:0]   fwd_addr_q;
	bb3_pkg::rgb_t      fwd_up_q;
	bb3_pkg::rgb_t      fwd_mid_q;
	bb3_pkg::rgb_t      win_q [3][3];

	// Stage 2
	logic                   vld_s2;
	bb3_pkg::bnd_t          bnd_s2;
	logic [2:0]             row_ok;
	logic [2:0]             col_ok;
	logic [1:0]             rows_n;
	logic [1:0]             cols_n;
	bb3_pkg::div_plan_t     plan;
	logic [SUM_W-1:0]       row_sum [NCH][3];
	logic [SUM_W-1:0]       ch_sum [NCH];
	logic [X_W-1:0]         x_s2 [NCH];

	// Stage 3
	logic                   vld_s3;
	logic                   last_s3;
	logic [1:0]             shift_s3;
	bb3_pkg::div_kind_e     kind_s3;
	logic [X_W-1:0]         x_s3 [NCH];
	logic [X_W-1:0]         y_s3 [NCH];
	logic [bb3_pkg::RECIP_W-1:0] recip;
	logic [PROD_W-1:0]      prod_s3 [NCH];
	bb3_pkg::rgb_t          q_s3;

	// Output register
	logic                   out_vld_q;
	bb3_pkg::rgb_t          out_pix_q;
	logic                   out_last_q;

	// Effective geometry from a config write
	always_comb begin
		raw_w = cfg_data[bb3_pkg::WIDTH_REG_W-1:0];
		raw_h = cfg_data[ROW_W-1:0];
		if (raw_w == '0) begin
			w_eff = WEFF_W'(1);
		end else if (32'(raw_w) > bb3_pkg::MAX_WIDTH) begin
			w_eff = WEFF_W'(bb3_pkg::MAX_WIDTH);
		end else begin
			w_eff = WEFF_W'(raw_w);
		end
	end

	// Whole pipe moves when the output register can take a new item
	assign advance       = !out_vld_q || m_axis_tready;
	assign s_axis_tready = advance && !prime_q;
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign is_pix        = (s_axis_tuser == bb3_pkg::CMD_PIXEL);

	// Stage 0: item decode and position bookkeeping
	always_comb begin
		restart  = acc && is_pix && done_q;
		col_cur  = restart ? '0 : in_col_q;
		row_cur  = restart ? '0 : in_row_q;
		pend_cur = restart ? '0 : pend_q;
		ocol_cur = restart ? '0 : out_col_q;
		orow_cur = restart ? '0 : out_row_q;
		drain_ok = done_q && (pend_q != '0);
		s0_we    = acc && is_pix;
		s0_go    = (acc && (is_pix || drain_ok)) || (prime_q && advance);
		s0_emit  = acc && (is_pix ? (pend_cur == pend_max_q) : drain_ok);

		col_wrap  = (col_cur == wlast_q);
		col_nxt   = col_wrap ? '0 : COL_W'(col_cur + 1'b1);
		row_nxt   = col_wrap ? ROW_W'(row_cur + 1'b1) : row_cur;
		frame_end = s0_we && col_wrap && (row_cur == hlast_q);

		if (s0_we) begin
			pend_nxt = s0_emit ? pend_cur : PEND_W'(pend_cur + 1'b1);
		end else if (s0_emit) begin
			pend_nxt = PEND_W'(pend_cur - 1'b1);
		end else begin
			pend_nxt = pend_cur;
		end

		// Next output position, raster order
		if (ocol_cur == wlast_q) begin
			ocol_nxt = '0;
			orow_nxt = (orow_cur == hlast_q) ? '0 : ROW_W'(orow_cur + 1'b1);
		end else begin
			ocol_nxt = COL_W'(ocol_cur + 1'b1);
			orow_nxt = orow_cur;
		end

		bnd_s0.top   = (orow_cur == '0);
		bnd_s0.bot   = (orow_cur == hlast_q);
		bnd_s0.left  = (ocol_cur == '0);
		bnd_s0.right = (ocol_cur == wlast_q);
	end

	// Control registers; a config write restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlast_q    <= COL_W'(bb3_pkg::RST_WIDTH - 1);
			hlast_q    <= ROW_W'(bb3_pkg::RST_HEIGHT - 1);
			pend_max_q <= PEND_W'(bb3_pkg::RST_WIDTH + 1);
			in_col_q   <= '0;
			in_row_q   <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			pend_q     <= '0;
			done_q     <= 1'b0;
			prime_q    <= 1'b0;
		end else if (cfg_wr_en) begin
			if (cfg_index == bb3_pkg::REG_IMAGE_WIDTH) begin
				wlast_q    <= COL_W'(w_eff - 1'b1);
				pend_max_q <= PEND_W'(w_eff) + PEND_W'(1);
			end else begin
				hlast_q <= (raw_h == '0) ? '0 : ROW_W'(raw_h - 1'b1);
			end
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pend_q    <= '0;
			done_q    <= 1'b0;
			prime_q   <= 1'b0;
		end else if (s0_go) begin
			in_col_q <= col_nxt;
			pend_q   <= pend_nxt;
			// A one-row frame ends short of the usual lag: step one column more
			prime_q  <= frame_end && (pend_nxt != pend_max_q);
			if (s0_we) begin
				in_row_q <= row_nxt;
				done_q   <= frame_end;
			end
			if (s0_emit) begin
				out_col_q <= ocol_nxt;
				out_row_q <= orow_nxt;
			end else if (restart) begin
				out_col_q <= '0;
				out_row_q <= '0;
			end
		end
	end

	// Line store: {row two up, row one up} per column
	bb3_ram #(
		.WIDTH (2 * PIX_W),
		.DEPTH (bb3_pkg::MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (addr_s1),
		.wdata ({col_mid, pix_s1}),
		.re    (advance),
		.raddr (col_cur),
		.rdata (rd_data)
	);

	// Stage 1 pipeline registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= s0_go;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			emit_s1 <= s0_emit;
			we_s1   <= s0_we;
			addr_s1 <= col_cur;
			pix_s1  <= s_axis_tdata;
			bnd_s1  <= bnd_s0;
		end
	end

	// Forward a write made in the same cycle as this item's read
	always_comb begin
		fwd_hit = fwd_vld_q && (fwd_addr_q == addr_s1);
		col_up  = fwd_hit ? fwd_up_q  : rd_data[2*PIX_W-1:PIX_W];
		col_mid = fwd_hit ? fwd_mid_q : rd_data[PIX_W-1:0];
		mem_we  = advance && vld_s1 && we_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
		end else if (advance) begin
			fwd_vld_q <= vld_s1 && we_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fwd_addr_q <= addr_s1;
			fwd_up_q   <= col_mid;
			fwd_mid_q  <= pix_s1;
		end
	end

	// Window shift: column 2 is newest, row 2 is the incoming row
	always_ff @(posedge clk) begin
		if (advance && vld_s1) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= col_up;
			win_q[1][2] <= col_mid;
			win_q[2][2] <= pix_s1;
		end
	end

	// Stage 2 pipeline registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= vld_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			bnd_s2 <= bnd_s1;
		end
	end

	// Stage 2: masked window sums and divisor plan
	always_comb begin
		row_ok = {!bnd_s2.bot, 1'b1, !bnd_s2.top};
		col_ok = {!bnd_s2.right, 1'b1, !bnd_s2.left};
		rows_n = 2'd1 + 2'(row_ok[0]) + 2'(row_ok[2]);
		cols_n = 2'd1 + 2'(col_ok[0]) + 2'(col_ok[2]);
		plan   = bb3_pkg::div_plan(rows_n, cols_n);
		for (int ch = 0; ch < NCH; ch++) begin
			for (int r = 0; r < 3; r++) begin
				row_sum[ch][r] = (col_ok[0] ? SUM_W'(win_q[r][0][ch]) : '0)
					+ SUM_W'(win_q[r][1][ch])
					+ (col_ok[2] ? SUM_W'(win_q[r][2][ch]) : '0);
			end
			ch_sum[ch] = (row_ok[0] ? row_sum[ch][0] : '0) + row_sum[ch][1]
				+ (row_ok[2] ? row_sum[ch][2] : '0);
			x_s2[ch] = {ch_sum[ch], 1'b0} + X_W'(plan.count);
		end
	end

	// Stage 3 pipeline registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (advance) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			last_s3  <= bnd_s2.bot && bnd_s2.right;
			shift_s3 <= plan.shift;
			kind_s3  <= plan.kind;
			for (int ch = 0; ch < NCH; ch++) begin
				x_s3[ch] <= x_s2[ch];
			end
		end
	end

	// Stage 3: (2*sum + count) / (2*count) as shift plus reciprocal multiply
	always_comb begin
		case (kind_s3)
			bb3_pkg::DIV_3: recip = bb3_pkg::RECIP_W'(bb3_pkg::RECIP_3);
			bb3_pkg::DIV_9: recip = bb3_pkg::RECIP_W'(bb3_pkg::RECIP_9);
			default:        recip = '0;
		endcase
		for (int ch = 0; ch < NCH; ch++) begin
			y_s3[ch]    = x_s3[ch] >> shift_s3;
			prod_s3[ch] = PROD_W'(y_s3[ch]) * PROD_W'(recip);
			if (kind_s3 == bb3_pkg::DIV_1) begin
				q_s3[ch] = y_s3[ch][CH_W-1:0];
			end else begin
				q_s3[ch] = prod_s3[ch][bb3_pkg::RECIP_SHIFT +: CH_W];
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_pix_q  <= q_s3;
			out_last_q <= last_s3;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_pix_q;
	assign m_axis_tlast  = out_last_q;

endmodule

// File: rtl/bb3_checker.sv
// ----------------------------------------------------------------------------
// bb3_checker
// Port-level checks of the box blur's stream handshakes, bound to the top.
// ----------------------------------------------------------------------------
`include "box_blur_3x3_rgb_defines.svh"

module bb3_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_axis_tvalid,
	input logic                      s_axis_tready,
	input logic                      m_axis_tvalid,
	input logic                      m_axis_tready,
	input logic [bb3_pkg::PIX_W-1:0] m_axis_tdata,
	input logic                      m_axis_tlast
);

	// A stalled result keeps its payload
	`BB3_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

	// A stalled result blocks new items
	`BB3_ASSERT_SAME(a_stall_blocks_in, m_axis_tvalid && !m_axis_tready, !s_axis_tready)

	// Ready drops only for back-pressure or the one-cycle closing step of a one-row frame
	`BB3_ASSERT_NEXT(a_ready_gap_short, !s_axis_tready && !m_axis_tvalid, s_axis_tready || m_axis_tvalid)

endmodule

bind box_blur_3x3_rgb bb3_checker u_bb3_checker (.*);
